>>> design/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotator.
// Used by qvr_matrix and quaternion_vector_rotator; depends on nothing.
`default_nettype none

package qvr_pkg;

    localparam int QVR_DATA_W    = 16;
    localparam int QVR_FRAC_BITS = 14;
    localparam int QVR_NUM_REGS  = 4;
    localparam int QVR_CFG_IDX_W = 2;

    // Cycles the input is held off after reset or a register write.
    localparam logic [1:0] QVR_SETTLE = 2'd3;

    typedef enum logic [QVR_CFG_IDX_W-1:0] {
        QVR_REG_QUAT_A = 2'd0,
        QVR_REG_QUAT_B = 2'd1,
        QVR_REG_QUAT_C = 2'd2,
        QVR_REG_QUAT_D = 2'd3
    } qvr_reg_t;

    typedef struct packed {
        logic signed [QVR_DATA_W-1:0] quat_a;
        logic signed [QVR_DATA_W-1:0] quat_b;
        logic signed [QVR_DATA_W-1:0] quat_c;
        logic signed [QVR_DATA_W-1:0] quat_d;
    } qvr_quat_t;

    typedef struct packed {
        logic signed [QVR_DATA_W-1:0] vec_x;
        logic signed [QVR_DATA_W-1:0] vec_y;
        logic signed [QVR_DATA_W-1:0] vec_z;
    } qvr_vec_t;

    typedef struct packed {
        logic signed [QVR_DATA_W-1:0] rot_x;
        logic signed [QVR_DATA_W-1:0] rot_y;
        logic signed [QVR_DATA_W-1:0] rot_z;
        logic                         clipped;
    } qvr_rot_t;

endpackage

`default_nettype wire

>>> design/qvr_matrix.sv
// Three-stage pipeline that turns the quaternion registers into the rounded 3x3 matrix.
// Depends on qvr_pkg.
`default_nettype none

module qvr_matrix #(
    parameter int FRAC_BITS = qvr_pkg::QVR_FRAC_BITS,
    localparam int EW = ((2 * qvr_pkg::QVR_DATA_W > 2 * FRAC_BITS + 1) ?
                         2 * qvr_pkg::QVR_DATA_W : 2 * FRAC_BITS + 1) + 2,
    localparam int RW = EW - FRAC_BITS
) (
    input  wire logic                aclk,
    input  wire qvr_pkg::qvr_quat_t  quat,
    output logic signed [RW-1:0]     mat [9]
);
    import qvr_pkg::*;

    localparam int PW = 2 * QVR_DATA_W;
    localparam logic signed [EW-1:0] EL_ONE  = EW'(64'd1 << (2 * FRAC_BITS));
    localparam logic signed [EW-1:0] EL_HALF = EW'(64'd1 << (FRAC_BITS - 1));

    logic signed [PW-1:0] bb_reg, cc_reg, dd_reg, ab_reg, ac_reg, ad_reg, bc_reg, bd_reg, cd_reg;
    logic signed [PW-1:0] bb_next, cc_next, dd_next, ab_next, ac_next, ad_next;
    logic signed [PW-1:0] bc_next, bd_next, cd_next;
    logic signed [EW-1:0] xbb, xcc, xdd, xab, xac, xad, xbc, xbd, xcd;
    logic signed [EW-1:0] elem_reg [9];
    logic signed [EW-1:0] elem_next [9];
    logic signed [EW-1:0] elem_half [9];
    logic signed [RW-1:0] mat_reg [9];
    logic signed [RW-1:0] mat_next [9];

    always_comb begin
        bb_next = PW'(quat.quat_b) * PW'(quat.quat_b);
        cc_next = PW'(quat.quat_c) * PW'(quat.quat_c);
        dd_next = PW'(quat.quat_d) * PW'(quat.quat_d);
        ab_next = PW'(quat.quat_a) * PW'(quat.quat_b);
        ac_next = PW'(quat.quat_a) * PW'(quat.quat_c);
        ad_next = PW'(quat.quat_a) * PW'(quat.quat_d);
        bc_next = PW'(quat.quat_b) * PW'(quat.quat_c);
        bd_next = PW'(quat.quat_b) * PW'(quat.quat_d);
        cd_next = PW'(quat.quat_c) * PW'(quat.quat_d);
    end

    always_comb begin
        xbb = EW'(bb_reg);
        xcc = EW'(cc_reg);
        xdd = EW'(dd_reg);
        xab = EW'(ab_reg);
        xac = EW'(ac_reg);
        xad = EW'(ad_reg);
        xbc = EW'(bc_reg);
        xbd = EW'(bd_reg);
        xcd = EW'(cd_reg);
        elem_next[0] = EL_ONE - ((xcc + xdd) <<< 1);
        elem_next[1] = (xbc - xad) <<< 1;
        elem_next[2] = (xbd + xac) <<< 1;
        elem_next[3] = (xbc + xad) <<< 1;
        elem_next[4] = EL_ONE - ((xbb + xdd) <<< 1);
        elem_next[5] = (xcd - xab) <<< 1;
        elem_next[6] = (xbd - xac) <<< 1;
        elem_next[7] = (xcd + xab) <<< 1;
        elem_next[8] = EL_ONE - ((xbb + xcc) <<< 1);
    end

    // Round to nearest, ties toward plus infinity.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            elem_half[k] = elem_reg[k] + EL_HALF;
            mat_next[k]  = elem_half[k][EW-1:FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        bb_reg <= bb_next;
        cc_reg <= cc_next;
        dd_reg <= dd_next;
        ab_reg <= ab_next;
        ac_reg <= ac_next;
        ad_reg <= ad_next;
        bc_reg <= bc_next;
        bd_reg <= bd_next;
        cd_reg <= cd_next;
        for (int k = 0; k < 9; k++) begin
            elem_reg[k] <= elem_next[k];
            mat_reg[k]  <= mat_next[k];
        end
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

>>> design/quaternion_vector_rotator.sv
// Quaternion vector rotator top level: register port, matrix pipeline and vector pipeline.
// Depends on qvr_pkg and qvr_matrix.
`default_nettype none

// Rotates signed vectors by the 3x3 matrix of the quaternion held in four Q1.14 registers.
// The vector path is a five-stage pipeline: one beat is taken every cycle while the output
// is not stalled, with stalls absorbed stage by stage. The matrix is rebuilt by its own
// three-stage pipeline, so after reset and after every register write s_ready stays low
// while the new matrix settles. Registers must only be written while no beat is in flight.
// Results are rounded to nearest and saturated; clipped marks a beat in which any component
// saturated.
module quaternion_vector_rotator #(
    parameter int FRAC_BITS = qvr_pkg::QVR_FRAC_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [qvr_pkg::QVR_CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [qvr_pkg::QVR_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire qvr_pkg::qvr_vec_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output qvr_pkg::qvr_rot_t                        m_data
);
    import qvr_pkg::*;

    localparam int DW  = QVR_DATA_W;
    localparam int EW  = ((2 * DW > 2 * FRAC_BITS + 1) ? 2 * DW : 2 * FRAC_BITS + 1) + 2;
    localparam int RW  = EW - FRAC_BITS;
    localparam int PRW = RW + DW;
    localparam int AW  = PRW + 2;
    localparam int RDW = AW - FRAC_BITS;
    localparam int NST = 5;

    localparam logic signed [DW-1:0]  QUAT_ONE = DW'(64'd1 << FRAC_BITS);
    localparam logic signed [AW-1:0]  ROW_HALF = AW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [RDW-1:0] SAT_MAX  = RDW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [RDW-1:0] SAT_MIN  = RDW'(-(64'sd1 <<< (DW - 1)));

    qvr_quat_t quat_reg, quat_next;
    logic [1:0] settle_reg, settle_next;

    logic signed [RW-1:0] mat [9];

    logic [NST-1:0] vld_reg, vld_next;
    logic [NST-1:0] adv;

    qvr_vec_t vec_reg, vec_next;
    logic signed [DW-1:0]  vcomp [3];
    logic signed [PRW-1:0] prod_reg [9];
    logic signed [PRW-1:0] prod_next [9];
    logic signed [AW-1:0]  sum_reg [3];
    logic signed [AW-1:0]  sum_next [3];
    logic signed [AW-1:0]  sum_half [3];
    logic signed [RDW-1:0] rnd_reg [3];
    logic signed [RDW-1:0] rnd_next [3];
    logic signed [DW-1:0]  sat_val [3];
    logic [2:0]            sat_hit;
    qvr_rot_t out_reg, out_next;

    always_comb begin
        quat_next = quat_reg;
        if (cfg_wr_en) begin
            unique case (qvr_reg_t'(cfg_index))
                QVR_REG_QUAT_A: quat_next.quat_a = cfg_wdata;
                QVR_REG_QUAT_B: quat_next.quat_b = cfg_wdata;
                QVR_REG_QUAT_C: quat_next.quat_c = cfg_wdata;
                QVR_REG_QUAT_D: quat_next.quat_d = cfg_wdata;
                default:        quat_next = quat_reg;
            endcase
        end
    end

    always_comb begin
        settle_next = settle_reg;
        if (cfg_wr_en) begin
            settle_next = QVR_SETTLE;
        end else if (settle_reg != 2'd0) begin
            settle_next = settle_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_reg   <= '{quat_a: QUAT_ONE, quat_b: '0, quat_c: '0, quat_d: '0};
            settle_reg <= QVR_SETTLE;
        end else begin
            quat_reg   <= quat_next;
            settle_reg <= settle_next;
        end
    end

    qvr_matrix #(
        .FRAC_BITS(FRAC_BITS)
    ) u_matrix (
        .aclk(aclk),
        .quat(quat_reg),
        .mat (mat)
    );

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        adv[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0] && (settle_reg == 2'd0);

    always_comb begin
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_valid && s_ready;
        end
        for (int i = 1; i < NST; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_comb begin
        vec_next = s_data;
        vcomp[0] = vec_reg.vec_x;
        vcomp[1] = vec_reg.vec_y;
        vcomp[2] = vec_reg.vec_z;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[3*r+c] = PRW'(mat[3*r+c]) * PRW'(vcomp[c]);
            end
        end
        for (int r = 0; r < 3; r++) begin
            sum_next[r] = AW'(prod_reg[3*r]) + AW'(prod_reg[3*r+1]) + AW'(prod_reg[3*r+2]);
            sum_half[r] = sum_reg[r] + ROW_HALF;
            rnd_next[r] = sum_half[r][AW-1:FRAC_BITS];
        end
        for (int r = 0; r < 3; r++) begin
            priority if (rnd_reg[r] > SAT_MAX) begin
                sat_val[r] = SAT_MAX[DW-1:0];
                sat_hit[r] = 1'b1;
            end else if (rnd_reg[r] < SAT_MIN) begin
                sat_val[r] = SAT_MIN[DW-1:0];
                sat_hit[r] = 1'b1;
            end else begin
                sat_val[r] = rnd_reg[r][DW-1:0];
                sat_hit[r] = 1'b0;
            end
        end
        out_next = '{rot_x: sat_val[0], rot_y: sat_val[1], rot_z: sat_val[2],
                     clipped: |sat_hit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            vec_reg <= vec_next;
        end
        if (adv[1]) begin
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (adv[2]) begin
            for (int r = 0; r < 3; r++) begin
                sum_reg[r] <= sum_next[r];
            end
        end
        if (adv[3]) begin
            for (int r = 0; r < 3; r++) begin
                rnd_reg[r] <= rnd_next[r];
            end
        end
        if (adv[4]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[NST-1];
    assign m_data  = out_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_quaternion_vector_rotator.sv
// Self-checking testbench for quaternion_vector_rotator: predicts each rotated vector
// in the bench and compares every result beat, with random stalls on both channels.
// Depends on qvr_pkg and the quaternion_vector_rotator RTL.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotator;

    import qvr_pkg::*;

    localparam longint SAT_MAX  = (longint'(1) <<< (QVR_DATA_W - 1)) - 1;
    localparam longint SAT_MIN  = -(longint'(1) <<< (QVR_DATA_W - 1));
    localparam longint HALF_LSB = longint'(1) <<< (QVR_FRAC_BITS - 1);
    localparam int     SETTLE_CYCLES = 10;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_wr_en = 1'b0;
    qvr_reg_t  cfg_index = QVR_REG_QUAT_A;
    logic [QVR_DATA_W-1:0] cfg_wdata = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    qvr_vec_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    qvr_rot_t  m_data;

    qvr_quat_t quat_cfg = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    qvr_rot_t  rot_expected [$];
    bit        quiet       = 1'b0;
    int        ready_hold  = 0;
    int        errors      = 0;
    int        vecs_sent   = 0;
    int        beats_seen  = 0;
    int        quat_loads  = 0;

    quaternion_vector_rotator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint round_frac_bits(input longint x);
        return (x + HALF_LSB) >>> QVR_FRAC_BITS;
    endfunction

    function automatic logic [QVR_DATA_W-1:0] clamp_word(input longint x, inout bit hit);
        if (x > SAT_MAX) begin
            hit = 1'b1;
            return SAT_MAX[QVR_DATA_W-1:0];
        end
        if (x < SAT_MIN) begin
            hit = 1'b1;
            return SAT_MIN[QVR_DATA_W-1:0];
        end
        return x[QVR_DATA_W-1:0];
    endfunction

    function automatic qvr_rot_t rotate_vec(input qvr_vec_t v);
        longint   a, b, c, d, one, acc;
        longint   m [9];
        longint   vin [3];
        logic [QVR_DATA_W-1:0] res [3];
        bit       hit;
        qvr_rot_t rot;
        a = longint'($signed(quat_cfg.quat_a));
        b = longint'($signed(quat_cfg.quat_b));
        c = longint'($signed(quat_cfg.quat_c));
        d = longint'($signed(quat_cfg.quat_d));
        one = longint'(1) <<< (2 * QVR_FRAC_BITS);
        m[0] = one - 2 * (c * c + d * d);
        m[1] = 2 * (b * c - a * d);
        m[2] = 2 * (b * d + a * c);
        m[3] = 2 * (b * c + a * d);
        m[4] = one - 2 * (b * b + d * d);
        m[5] = 2 * (c * d - a * b);
        m[6] = 2 * (b * d - a * c);
        m[7] = 2 * (c * d + a * b);
        m[8] = one - 2 * (b * b + c * c);
        foreach (m[i]) m[i] = round_frac_bits(m[i]);
        vin[0] = longint'($signed(v.vec_x));
        vin[1] = longint'($signed(v.vec_y));
        vin[2] = longint'($signed(v.vec_z));
        hit = 1'b0;
        for (int r = 0; r < 3; r++) begin
            acc = m[3*r] * vin[0] + m[3*r+1] * vin[1] + m[3*r+2] * vin[2];
            res[r] = clamp_word(round_frac_bits(acc), hit);
        end
        rot.rot_x   = res[0];
        rot.rot_y   = res[1];
        rot.rot_z   = res[2];
        rot.clipped = hit;
        return rot;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [QVR_DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic qvr_vec_t random_vec();
        qvr_vec_t v;
        v.vec_x = random_word();
        v.vec_y = random_word();
        v.vec_z = random_word();
        return v;
    endfunction

    function automatic qvr_vec_t mk_vec(input int x, input int y, input int z);
        qvr_vec_t v;
        v.vec_x = 16'(x);
        v.vec_y = 16'(y);
        v.vec_z = 16'(z);
        return v;
    endfunction

    function automatic qvr_quat_t mk_quat(input int a, input int b, input int c, input int d);
        qvr_quat_t q;
        q.quat_a = 16'(a);
        q.quat_b = 16'(b);
        q.quat_c = 16'(c);
        q.quat_d = 16'(d);
        return q;
    endfunction

    function automatic qvr_quat_t random_quat();
        real       ra, rb, rc, rd, norm;
        qvr_quat_t q;
        if ($urandom_range(0, 9) < 6) begin
            ra = real'(int'($urandom_range(0, 32768)) - 16384);
            rb = real'(int'($urandom_range(0, 32768)) - 16384);
            rc = real'(int'($urandom_range(0, 32768)) - 16384);
            rd = real'(int'($urandom_range(0, 32768)) - 16384);
            norm = $sqrt(ra * ra + rb * rb + rc * rc + rd * rd);
            if (norm < 1.0) begin
                ra = 1.0;
                norm = 1.0;
            end
            q = mk_quat($rtoi(ra * 16384.0 / norm), $rtoi(rb * 16384.0 / norm),
                        $rtoi(rc * 16384.0 / norm), $rtoi(rd * 16384.0 / norm));
        end else begin
            q.quat_a = random_word();
            q.quat_b = random_word();
            q.quat_c = random_word();
            q.quat_d = random_word();
        end
        return q;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 100) $display("MISMATCH at %0t ns, beat %0d: %s", $time, beats_seen, msg);
    endtask

    task automatic send_vec(input qvr_vec_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rot_expected.push_back(rotate_vec(v));
        vecs_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (rot_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_quat(input qvr_quat_t q);
        qvr_reg_t              reg_seq [4];
        logic [QVR_DATA_W-1:0] part [4];
        reg_seq = '{QVR_REG_QUAT_A, QVR_REG_QUAT_B, QVR_REG_QUAT_C, QVR_REG_QUAT_D};
        part    = '{q.quat_a, q.quat_b, q.quat_c, q.quat_d};
        drain_results();
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_seq[i];
            cfg_wdata <= part[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        quat_cfg = q;
        quat_loads++;
    endtask

    always @(posedge aclk) begin : rx_stall
        int stall_len;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            stall_len = pick_gap();
            m_ready    <= (stall_len == 0);
            ready_hold <= (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    always @(posedge aclk) begin : result_check
        qvr_rot_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (rot_expected.size() == 0) begin
                report_mismatch("result beat with no expectation pending");
            end else begin
                want = rot_expected.pop_front();
                if (m_data.rot_x !== want.rot_x)
                    report_mismatch($sformatf("rot_x got %0d expected %0d",
                                              m_data.rot_x, want.rot_x));
                if (m_data.rot_y !== want.rot_y)
                    report_mismatch($sformatf("rot_y got %0d expected %0d",
                                              m_data.rot_y, want.rot_y));
                if (m_data.rot_z !== want.rot_z)
                    report_mismatch($sformatf("rot_z got %0d expected %0d",
                                              m_data.rot_z, want.rot_z));
                if (m_data.clipped !== want.clipped)
                    report_mismatch($sformatf("clipped got %b expected %b",
                                              m_data.clipped, want.clipped));
            end
        end
    end

    task automatic test_identity_passthrough();
        send_vec(mk_vec(0, 0, 0));
        send_vec(mk_vec(32767, 32767, 32767));
        send_vec(mk_vec(-32768, -32768, -32768));
        send_vec(mk_vec(32767, -32768, 1));
        send_vec(mk_vec(-1, 0, -32768));
        send_vec(mk_vec(21845, -21846, 4660));
    endtask

    task automatic test_directed_quats();
        load_quat(mk_quat(11585, 0, 0, 11585));
        send_vec(mk_vec(10000, 0, 0));
        send_vec(mk_vec(0, -10000, 0));
        send_vec(mk_vec(32767, 32767, -32768));
        send_vec(mk_vec(-32768, 32767, 0));
        load_quat(mk_quat(32767, 32767, 32767, 32767));
        send_vec(mk_vec(1, 0, 0));
        send_vec(mk_vec(0, 0, 0));
        send_vec(mk_vec(100, -100, 50));
        send_vec(mk_vec(-32768, 32767, -32768));
        load_quat(mk_quat(-32768, -32768, -32768, -32768));
        send_vec(mk_vec(1, 1, 1));
        send_vec(mk_vec(0, 0, 0));
        send_vec(mk_vec(-5, 7, -9));
        send_vec(mk_vec(32767, 0, -32768));
        load_quat(mk_quat(32767, -32768, 0, 1));
        send_vec(mk_vec(1, 2, 3));
        send_vec(mk_vec(32767, 32767, 32767));
        send_vec(mk_vec(-32768, -1, 0));
    endtask

    task automatic test_random_rotations();
        for (int phase = 0; phase < 13; phase++) begin
            load_quat(random_quat());
            repeat (60) send_vec(random_vec());
        end
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        for (int phase = 0; phase < 2; phase++) begin
            load_quat(random_quat());
            repeat (60) send_vec(random_vec());
        end
        drain_results();
        quiet = 1'b0;
    endtask

    initial begin : watchdog
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_identity_passthrough();
        test_directed_quats();
        test_random_rotations();
        test_full_rate();
        drain_results();
        repeat (20) @(posedge aclk);
        $display("Rotated %0d vectors under %0d quaternion loads plus the reset identity;",
                 vecs_sent, quat_loads);
        $display("%0d result beats checked, %0d mismatches.", beats_seen, errors);
        if (errors == 0 && rot_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> quaternion_vector_rotator.f
design/qvr_pkg.sv
design/qvr_matrix.sv
design/quaternion_vector_rotator.sv
tb/sv/tb_quaternion_vector_rotator.sv
